### hdl/plist_pkg.sv
package plist_pkg;

   // Sizing of the store
   localparam int CAPACITY   = 64;
   localparam int VALUE_BITS = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int COUNT_W    = $clog2(CAPACITY + 1);

   // Transaction field widths
   localparam int OP_W    = 2;
   localparam int POS_W   = 7;
   localparam int ITEM_W  = 32;
   localparam int OUT_W   = 32;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   // Store write port request
   typedef struct packed {
      logic                  en;
      logic [ADDR_W-1:0]     addr;
      logic [VALUE_BITS-1:0] data;
   } wr_req_type;

   // Store read port request
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } rd_req_type;

endpackage

### hdl/plist_store.sv
module plist_store (
   input  logic                             clock,
   input  plist_pkg::wr_req_type            wr_req,
   input  plist_pkg::rd_req_type            rd_req,
   output logic [plist_pkg::VALUE_BITS-1:0] rd_data
);

   logic [plist_pkg::VALUE_BITS-1:0] mem [plist_pkg::CAPACITY];
   logic [plist_pkg::VALUE_BITS-1:0] rd_data_ff;

   // One write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr] <= wr_req.data;
      end
      if (rd_req.en) begin
         rd_data_ff <= mem[rd_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/positional_list_engine.sv
// Positional list engine: holds an ordered sequence of up to 64 value handles in a
// single synchronous store and serves one operation per transaction. Insert places
// req_item_value at req_position and moves later entries up; remove returns the
// entry at req_position and closes the gap; read returns it unchanged. An index out
// of range, a full store on insert or an unknown opcode gives rsp_ok low and
// rsp_out_value zero. Every response carries the entry count after the operation.
// Items are handled one at a time; insert and remove shift the later entries one
// slot each, except an insert at the tail, which moves nothing. The store's single
// write port moves one entry per cycle while the registered read port fetches the
// next one ahead of it. A finished response waits in an output register, so the
// next transaction may be accepted while it is still stalled.
module positional_list_engine (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [plist_pkg::OP_W-1:0]    req_op,
   input  logic [plist_pkg::POS_W-1:0]   req_position,
   input  logic [plist_pkg::ITEM_W-1:0]  req_item_value,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_ok,
   output logic [plist_pkg::OUT_W-1:0]   rsp_out_value,
   output logic [plist_pkg::COUNT_W-1:0] rsp_entry_count
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // Control
   state_type                          state_ff,     state_in;
   logic [plist_pkg::COUNT_W-1:0]      count_ff,     count_in;
   logic [plist_pkg::COUNT_W-1:0]      rd_left_ff,   rd_left_in;
   logic                               pend_ff,      pend_in;
   logic                               first_ff,     first_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // Transaction context
   logic [plist_pkg::OP_W-1:0]         op_ff,        op_in;
   logic [plist_pkg::ADDR_W-1:0]       pos_ff,       pos_in;
   logic [plist_pkg::VALUE_BITS-1:0]   val_ff,       val_in;
   logic [plist_pkg::ADDR_W-1:0]       rd_addr_ff,   rd_addr_in;
   logic [plist_pkg::ADDR_W-1:0]       rd_prev_ff,   rd_prev_in;
   logic                               ok_ff,        ok_in;
   logic [plist_pkg::VALUE_BITS-1:0]   res_ff,       res_in;

   // Response register
   logic                               rsp_ok_ff,    rsp_ok_in;
   logic [plist_pkg::OUT_W-1:0]        rsp_value_ff, rsp_value_in;
   logic [plist_pkg::COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   // Store ports
   plist_pkg::wr_req_type              wr_req;
   plist_pkg::rd_req_type              rd_req;
   logic [plist_pkg::VALUE_BITS-1:0]   rd_data;

   plist_store u_store (
      .clock   (clock),
      .wr_req  (wr_req),
      .rd_req  (rd_req),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      logic ins_ok;
      logic acc_ok;

      state_in     = state_ff;
      count_in     = count_ff;
      rd_left_in   = rd_left_ff;
      pend_in      = pend_ff;
      first_in     = first_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      rd_addr_in   = rd_addr_ff;
      rd_prev_in   = rd_prev_ff;
      ok_in        = ok_ff;
      res_in       = res_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      wr_req       = '0;
      rd_req       = '0;

      // Insert needs room and a position no further than the tail
      ins_ok = (req_position <= count_ff) && (count_ff < plist_pkg::COUNT_W'(plist_pkg::CAPACITY));
      acc_ok = (req_position < count_ff);

      // Drop the response once it has been taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_op;
               pos_in     = plist_pkg::ADDR_W'(req_position);
               val_in     = plist_pkg::VALUE_BITS'(req_item_value);
               ok_in      = 1'b0;
               res_in     = '0;
               pend_in    = 1'b0;
               first_in   = (req_op != plist_pkg::OP_INSERT);
               rd_left_in = '0;
               state_in   = ST_DONE;
               case (req_op)
                  plist_pkg::OP_INSERT: begin
                     if (ins_ok) begin
                        // Walk down from the last entry, one move per cycle
                        rd_left_in = count_ff - plist_pkg::COUNT_W'(req_position);
                        rd_addr_in = plist_pkg::ADDR_W'(count_ff - 1'b1);
                        state_in   = ST_RUN;
                     end
                  end
                  plist_pkg::OP_REMOVE: begin
                     if (acc_ok) begin
                        // First fetch is the removed entry, the rest close the gap
                        rd_left_in = count_ff - plist_pkg::COUNT_W'(req_position);
                        rd_addr_in = plist_pkg::ADDR_W'(req_position);
                        state_in   = ST_RUN;
                     end
                  end
                  plist_pkg::OP_READ: begin
                     if (acc_ok) begin
                        rd_left_in = plist_pkg::COUNT_W'(1);
                        rd_addr_in = plist_pkg::ADDR_W'(req_position);
                        state_in   = ST_RUN;
                     end
                  end
                  default: begin
                     // Unknown opcode: answer with a failure and no change
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_RUN: begin
            // Retire the fetch issued last cycle
            if (pend_ff) begin
               if (first_ff) begin
                  res_in   = rd_data;
                  first_in = 1'b0;
               end else begin
                  wr_req.en   = 1'b1;
                  wr_req.addr = (op_ff == plist_pkg::OP_INSERT) ? rd_prev_ff + 1'b1
                                                                : rd_prev_ff - 1'b1;
                  wr_req.data = rd_data;
               end
            end

            // Issue the next fetch, or finish once the pipe is empty
            if (rd_left_ff != '0) begin
               rd_req.en   = 1'b1;
               rd_req.addr = rd_addr_ff;
               rd_prev_in  = rd_addr_ff;
               rd_addr_in  = (op_ff == plist_pkg::OP_INSERT) ? rd_addr_ff - 1'b1
                                                             : rd_addr_ff + 1'b1;
               rd_left_in  = rd_left_ff - 1'b1;
               pend_in     = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  ok_in    = 1'b1;
                  state_in = ST_DONE;
                  if (op_ff == plist_pkg::OP_INSERT) begin
                     // Write port is free now: drop the new value into its slot
                     wr_req.en   = 1'b1;
                     wr_req.addr = pos_ff;
                     wr_req.data = val_ff;
                     count_in    = count_ff + 1'b1;
                  end else if (op_ff == plist_pkg::OP_REMOVE) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end
         end

         ST_DONE: begin
            // Hold until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_value_in = plist_pkg::OUT_W'(res_ff);
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_left_ff   <= '0;
         pend_ff      <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_left_ff   <= rd_left_in;
         pend_ff      <= pend_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      rd_addr_ff   <= rd_addr_in;
      rd_prev_ff   <= rd_prev_in;
      ok_ff        <= ok_in;
      res_ff       <= res_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

   // The count never goes past the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= plist_pkg::COUNT_W'(plist_pkg::CAPACITY))
      else $error("entry count above capacity");

   // Shifting never reads and writes the same entry in one cycle
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr_req.en && rd_req.en) |-> (wr_req.addr != rd_req.addr))
      else $error("store read and write collide");

   // A failed operation never returns data
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_value_ff == '0))
      else $error("failed response carries a value");

   // An accepted transaction always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted transaction not started");

endmodule
